/* hdl/pptf_pkg.sv */
// ----------------------------------------------------------------------------
// pptf_pkg
// Shared types, constants and helpers of the position/parameter tx framer.
// ----------------------------------------------------------------------------
package pptf_pkg;

  localparam int NUM_PARAMS = 4;
  localparam int IDX_W      = 2;
  localparam int DATA_W     = 8;
  localparam int MM_W       = 16;
  localparam int POS_W      = 7;
  localparam int REM_W      = 3;
  localparam int CMD_W      = 2;
  localparam int IN_TDATA_W = 32;

  // reciprocal of five, exact for 16-bit dividends with an 18-bit shift
  localparam logic [16:0] RECIP5      = 17'h0CCCD;
  localparam int          RECIP_SHIFT = 18;
  localparam int          QUOT_W      = MM_W - 2;

  localparam logic [DATA_W-1:0] CHAR_0     = 8'h30;
  localparam logic [DATA_W-1:0] CHAR_A     = 8'h41;
  localparam logic [DATA_W-1:0] HEX_ALPHA  = 8'h37;
  localparam logic [DATA_W-1:0] BYTE_IDLE  = 8'h00;
  localparam logic [3:0]        NIB_TEN    = 4'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET  = 2'd0,
    CMD_MARK = 2'd1,
    CMD_XMIT = 2'd2,
    CMD_NOP  = 2'd3
  } pptf_cmd_e;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_HIGH  = 3'b010,
    PH_LOW   = 3'b100
  } pptf_phase_e;

  typedef struct packed {
    logic              wr;
    logic              mark;
    logic              clr_low;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } pptf_bank_req_t;

  typedef struct packed {
    logic              any;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
  } pptf_bank_sts_t;

  function automatic logic [DATA_W-1:0] param_reset(input int i);
    logic [DATA_W-1:0] v;
    case (i)
      1:       v = 8'hf0;
      3:       v = 8'hff;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] hex_digit(input logic [3:0] nib);
    logic [DATA_W-1:0] v;
    if (nib < NIB_TEN) begin
      v = CHAR_0 + {4'b0, nib};
    end else begin
      v = HEX_ALPHA + {4'b0, nib};
    end
    return v;
  endfunction

endpackage

/* hdl/pptf_odometer.sv */
// ----------------------------------------------------------------------------
// pptf_odometer
// Accumulates odometer distance into a wheel position in 5 mm steps.
// ----------------------------------------------------------------------------
module pptf_odometer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [pptf_pkg::MM_W-1:0]  mm_i,
  output logic [pptf_pkg::POS_W-1:0] pos_o
);
  import pptf_pkg::*;

  logic [MM_W-1:0]   prev_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [POS_W-1:0]  wheel_q, wheel_d;
  logic [MM_W-1:0]   delta;
  logic [MM_W-1:0]   sum;
  logic [32:0]       prod;
  logic [QUOT_W-1:0] quot;
  logic [MM_W-1:0]   rem_full;

  always_comb begin
    delta    = mm_i - prev_q;
    sum      = delta + {{(MM_W-REM_W){1'b0}}, rem_q};
    prod     = {17'b0, sum} * {16'b0, RECIP5};
    quot     = prod[RECIP_SHIFT +: QUOT_W];
    rem_full = sum - {quot, 2'b00} - {2'b00, quot};
    rem_d    = rem_full[REM_W-1:0];
    wheel_d  = wheel_q + quot[POS_W-1:0];
  end

  assign pos_o = wheel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      rem_q   <= '0;
      wheel_q <= '0;
    end else if (step_i) begin
      prev_q  <= mm_i;
      rem_q   <= rem_d;
      wheel_q <= wheel_d;
    end
  end

endmodule

/* hdl/pptf_param_bank.sv */
// ----------------------------------------------------------------------------
// pptf_param_bank
// Parameter store with pending mask and lowest-pending lookup.
// ----------------------------------------------------------------------------
module pptf_param_bank (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pptf_pkg::pptf_bank_req_t req_i,
  output pptf_pkg::pptf_bank_sts_t sts_o
);
  import pptf_pkg::*;

  logic [DATA_W-1:0]     store_q [NUM_PARAMS];
  logic [NUM_PARAMS-1:0] pend_q, pend_d;
  logic [IDX_W-1:0]      low_idx;
  logic                  idx_ok;

  always_comb begin
    low_idx = '0;
    for (int i = NUM_PARAMS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  assign idx_ok = int'(req_i.idx) < NUM_PARAMS;

  assign sts_o.any   = |pend_q;
  assign sts_o.idx   = low_idx;
  assign sts_o.value = store_q[low_idx];

  always_comb begin
    pend_d = pend_q;
    if ((req_i.wr || req_i.mark) && idx_ok) begin
      pend_d[req_i.idx] = 1'b1;
    end
    if (req_i.clr_low) begin
      pend_d[low_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      for (int i = 0; i < NUM_PARAMS; i++) begin
        store_q[i] <= param_reset(i);
      end
    end else begin
      pend_q <= pend_d;
      if (req_i.wr && idx_ok) begin
        store_q[req_i.idx] <= req_i.data;
      end
    end
  end

endmodule

/* hdl/position_param_tx_framer.sv */
// ----------------------------------------------------------------------------
// position_param_tx_framer
// Builds a one-byte-per-transmit stream of wheel positions and parameter frames.
// A transfer is taken into the input register, and a transmit goes from there
// straight into the result register that drives m_tdata_o.
// Throughput: one transfer per cycle; a transmit waiting on a held result
// stays in the input register and holds off s_tready_o until m_tready_i.
// Reset: asynchronous, clears valid flags, framer and odometer state and restores parameter defaults.
// ----------------------------------------------------------------------------
module position_param_tx_framer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  // param_index[1:0], param_data[9:2], position_mm[25:10], zero pad
  input  logic [pptf_pkg::IN_TDATA_W-1:0]    s_tdata_i,
  // cmd[1:0]
  input  logic [pptf_pkg::CMD_W-1:0]         s_tuser_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  // tx_byte[7:0]
  output logic [pptf_pkg::DATA_W-1:0]        m_tdata_o
);
  import pptf_pkg::*;

  // input register
  logic              in_vld_q, in_vld_d;
  pptf_cmd_e         in_cmd_q;
  logic [IDX_W-1:0]  in_idx_q;
  logic [DATA_W-1:0] in_data_q;
  logic [MM_W-1:0]   in_mm_q;

  // framer state
  pptf_phase_e       phase_q, phase_d;
  logic [DATA_W-1:0] latched_q, latched_d;
  logic [POS_W-1:0]  last_pos_q, last_pos_d;
  logic              just_sent_q, just_sent_d;

  // result register
  logic              out_vld_q, out_vld_d;
  logic [DATA_W-1:0] tx_byte_q, tx_byte_d;

  logic              s_fire, is_xmit, out_free, advance;
  logic              idle, moved;
  logic [POS_W-1:0]  pos;
  pptf_bank_req_t    bank_req;
  pptf_bank_sts_t    bank_sts;

  assign s_fire   = s_tvalid_i && s_tready_o;
  assign is_xmit  = in_cmd_q == CMD_XMIT;
  assign out_free = !out_vld_q || m_tready_i;
  assign advance  = in_vld_q && (!is_xmit || out_free);

  assign s_tready_o = !in_vld_q || advance;
  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = tx_byte_q;

  pptf_odometer u_odometer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance && is_xmit),
    .mm_i   (in_mm_q),
    .pos_o  (pos)
  );

  pptf_param_bank u_param_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (bank_req),
    .sts_o  (bank_sts)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_fire) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    latched_d   = latched_q;
    last_pos_d  = last_pos_q;
    just_sent_d = just_sent_q;
    tx_byte_d   = tx_byte_q;
    out_vld_d   = out_vld_q && !m_tready_i;

    bank_req.wr      = advance && (in_cmd_q == CMD_SET);
    bank_req.mark    = advance && (in_cmd_q == CMD_MARK);
    bank_req.clr_low = 1'b0;
    bank_req.idx     = in_idx_q;
    bank_req.data    = in_data_q;

    idle  = !bank_sts.any && (phase_q != PH_HIGH) && (phase_q != PH_LOW);
    moved = (pos != last_pos_q) && !just_sent_q;

    if (advance && is_xmit) begin
      out_vld_d = 1'b1;
      if (idle || moved) begin
        tx_byte_d   = {1'b1, pos};
        last_pos_d  = pos;
        just_sent_d = 1'b1;
      end else begin
        just_sent_d = 1'b0;
        case (phase_q)
          PH_HIGH: begin
            tx_byte_d = hex_digit(latched_q[7:4]);
            phase_d   = PH_LOW;
          end
          PH_LOW: begin
            tx_byte_d = hex_digit(latched_q[3:0]);
            phase_d   = PH_START;
          end
          default: begin
            phase_d = PH_START;
            if (bank_sts.any) begin
              tx_byte_d        = CHAR_A + {{(DATA_W-IDX_W){1'b0}}, bank_sts.idx};
              latched_d        = bank_sts.value;
              bank_req.clr_low = 1'b1;
              phase_d          = PH_HIGH;
            end else begin
              tx_byte_d = BYTE_IDLE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      phase_q     <= PH_START;
      latched_q   <= '0;
      last_pos_q  <= '0;
      just_sent_q <= 1'b0;
    end else begin
      in_vld_q    <= in_vld_d;
      out_vld_q   <= out_vld_d;
      phase_q     <= phase_d;
      latched_q   <= latched_d;
      last_pos_q  <= last_pos_d;
      just_sent_q <= just_sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_cmd_q  <= pptf_cmd_e'(s_tuser_i);
      in_idx_q  <= s_tdata_i[IDX_W-1:0];
      in_data_q <= s_tdata_i[IDX_W +: DATA_W];
      in_mm_q   <= s_tdata_i[IDX_W+DATA_W +: MM_W];
    end
    tx_byte_q <= tx_byte_d;
  end

`ifndef SYNTH
  // a transmit leaving the input register always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && is_xmit |=> m_tvalid_o)
    else $error("transmit transfer lost");

  // the byte on the output agrees with the position-sent flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o[DATA_W-1] == just_sent_q))
    else $error("position flag out of step with output byte");

  // with nothing pending the position is always sent, so zero never goes out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o != BYTE_IDLE))
    else $error("idle byte transmitted");
`endif

endmodule
